/* sv/segment_rect_collision_check_core_defines.svh */
// assertion macros shared by the collision checker
`ifndef SEGMENT_RECT_COLLISION_CHECK_CORE_DEFINES_SVH
`define SEGMENT_RECT_COLLISION_CHECK_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define SRCC_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// property that must hold on the clock after a trigger
`define SRCC_ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (expr)) \
        else $error(msg);

`else

`define SRCC_ASSERT(label, expr, msg)
`define SRCC_ASSERT_NEXT(label, trig, expr, msg)

`endif

`endif

/* sv/srcc_pkg.sv */
`timescale 1ns / 1ps

package srcc_pkg;

    // sizing
    localparam int MAX_OBSTACLES = 16;
    localparam int COORD_BITS    = 16;
    localparam int IN_BITS       = 16;
    localparam int SLOT_BITS     = 4;
    localparam int COUNT_BITS    = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);
    localparam int DIFF_W        = COORD_BITS + 2;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int NUMB_W        = PROD_W + 1;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1,
        REG_OBST_COUNT = 2'd2
    } cfg_reg_t;

    typedef logic [COORD_BITS-1:0]         coord_t;
    typedef logic [COORD_BITS:0]           corner_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [NUMB_W-1:0]      numb_t;
    typedef logic [CNT_W-1:0]              cnt_t;

    // query traveling down the cell row
    typedef struct packed {
        logic   valid;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        diff_t  dpx;
        diff_t  dpy;
        cnt_t   rem;
        logic   oom;
        logic   blocked;
        logic   crossed;
    } token_t;

    // obstacle written by a load beat
    typedef struct packed {
        coord_t left;
        coord_t bottom;
        coord_t width;
        coord_t height;
    } load_t;

    // result flags
    typedef struct packed {
        logic oom;
        logic blocked;
        logic crossed;
    } res_t;

    // keep the low coordinate bits of an input field
    function automatic coord_t coord_of(logic [IN_BITS-1:0] v);
        return coord_t'(v);
    endfunction

    function automatic diff_t diff_of_coord(coord_t v);
        return $signed({2'b00, v});
    endfunction

    function automatic diff_t diff_of_corner(corner_t v);
        return $signed({1'b0, v});
    endfunction

    // num/den within [0,1] without dividing, den nonzero
    function automatic logic in_range(numb_t num, numb_t den);
        logic r;
        if (den > 0) begin
            r = (num >= 0) && (num <= den);
        end else begin
            r = (num <= 0) && (num >= den);
        end
        return r;
    endfunction

endpackage

/* sv/srcc_cell.sv */
`timescale 1ns / 1ps

module srcc_cell import srcc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  token_t tok_in,
    input  logic   ld_en,
    input  load_t  ld,
    output token_t tok_out
);

    coord_t  left_reg, bottom_reg, width_reg, height_reg;
    corner_t right_reg, top_reg;

    token_t tok_reg;
    prod_t  den_h_reg, den_v_reg, pxt_reg, pxb_reg, pyl_reg, pyr_reg;

    diff_t dpx_in, dpy_in, ndpx_in, ndpy_in;
    diff_t ry_top_in, ry_bot_in, rx_lft_in, rx_rgt_in;
    prod_t den_h_next, den_v_next, pxt_next, pxb_next, pyl_next, pyr_next;

    diff_t dpx_q, dpy_q, ndpx_q, ndpy_q;
    diff_t ry_top_q, ry_bot_q, rx_lft_q, rx_rgt_q;
    numb_t nb_top, nb_bot, nb_rgt;
    logic  hit_top, hit_bot, hit_lft, hit_rgt;
    logic  blk_a, blk_b, active;

    // obstacle held by this cell, far corner kept precomputed
    always_ff @(posedge aclk) begin
        if (ld_en) begin
            left_reg   <= ld.left;
            bottom_reg <= ld.bottom;
            width_reg  <= ld.width;
            height_reg <= ld.height;
            right_reg  <= {1'b0, ld.left} + {1'b0, ld.width};
            top_reg    <= {1'b0, ld.bottom} + {1'b0, ld.height};
        end
    end

    // products for the four sides, axis alignment leaves six
    always_comb begin
        dpx_in     = tok_in.dpx;
        dpy_in     = tok_in.dpy;
        ndpx_in    = -dpx_in;
        ndpy_in    = -dpy_in;
        ry_top_in  = diff_of_coord(tok_in.ay) - diff_of_corner(top_reg);
        ry_bot_in  = diff_of_coord(tok_in.ay) - diff_of_coord(bottom_reg);
        rx_lft_in  = diff_of_coord(tok_in.ax) - diff_of_coord(left_reg);
        rx_rgt_in  = diff_of_coord(tok_in.ax) - diff_of_corner(right_reg);
        den_h_next = prod_t'(diff_of_coord(width_reg)) * prod_t'(ndpy_in);
        den_v_next = prod_t'(diff_of_coord(height_reg)) * prod_t'(ndpx_in);
        pxt_next   = prod_t'(dpx_in) * prod_t'(ry_top_in);
        pxb_next   = prod_t'(dpx_in) * prod_t'(ry_bot_in);
        pyl_next   = prod_t'(dpy_in) * prod_t'(rx_lft_in);
        pyr_next   = prod_t'(dpy_in) * prod_t'(rx_rgt_in);
    end

    always_ff @(posedge aclk) begin
        den_h_reg <= den_h_next;
        den_v_reg <= den_v_next;
        pxt_reg   <= pxt_next;
        pxb_reg   <= pxb_next;
        pyl_reg   <= pyl_next;
        pyr_reg   <= pyr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_in;
        end
    end

    // range tests; the parameter along the edge scales out by its length
    always_comb begin
        dpx_q    = tok_reg.dpx;
        dpy_q    = tok_reg.dpy;
        ndpx_q   = -dpx_q;
        ndpy_q   = -dpy_q;
        ry_top_q = diff_of_coord(tok_reg.ay) - diff_of_corner(top_reg);
        ry_bot_q = diff_of_coord(tok_reg.ay) - diff_of_coord(bottom_reg);
        rx_lft_q = diff_of_coord(tok_reg.ax) - diff_of_coord(left_reg);
        rx_rgt_q = diff_of_coord(tok_reg.ax) - diff_of_corner(right_reg);
        nb_top   = numb_t'(pxt_reg) - numb_t'(pyl_reg);
        nb_bot   = numb_t'(pxb_reg) - numb_t'(pyl_reg);
        nb_rgt   = numb_t'(pxt_reg) - numb_t'(pyr_reg);

        hit_top = (den_h_reg != 0)
                  && in_range(numb_t'(ry_top_q), numb_t'(ndpy_q))
                  && in_range(nb_top, numb_t'(den_h_reg));
        hit_bot = (den_h_reg != 0)
                  && in_range(numb_t'(ry_bot_q), numb_t'(ndpy_q))
                  && in_range(nb_bot, numb_t'(den_h_reg));
        hit_lft = (den_v_reg != 0)
                  && in_range(numb_t'(rx_lft_q), numb_t'(ndpx_q))
                  && in_range(nb_top, numb_t'(den_v_reg));
        hit_rgt = (den_v_reg != 0)
                  && in_range(numb_t'(rx_rgt_q), numb_t'(ndpx_q))
                  && in_range(nb_rgt, numb_t'(den_v_reg));

        blk_a = (tok_reg.ax >= left_reg) && ({1'b0, tok_reg.ax} <= right_reg)
                && (tok_reg.ay >= bottom_reg) && ({1'b0, tok_reg.ay} <= top_reg);
        blk_b = (tok_reg.bx >= left_reg) && ({1'b0, tok_reg.bx} <= right_reg)
                && (tok_reg.by >= bottom_reg) && ({1'b0, tok_reg.by} <= top_reg);

        active = (tok_reg.rem != '0);
    end

    // fold this obstacle into the flags and hand the query on
    always_comb begin
        tok_out = tok_reg;
        if (active) begin
            tok_out.blocked = tok_reg.blocked | blk_a | blk_b;
            tok_out.crossed = tok_reg.crossed | hit_top | hit_bot | hit_lft | hit_rgt;
            tok_out.rem     = tok_reg.rem - cnt_t'(1);
        end
    end

endmodule

/* sv/srcc_chain.sv */
`timescale 1ns / 1ps

module srcc_chain import srcc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  token_t               tok_in,
    input  logic                 ld_valid,
    input  logic [SLOT_BITS-1:0] ld_slot,
    input  load_t                ld,
    output token_t               tok_out
);

    token_t                   tok_link [0:MAX_OBSTACLES];
    logic [MAX_OBSTACLES-1:0] ld_en;

    assign tok_link[0] = tok_in;

    // one cell per table entry, the query advances one cell per clock
    for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
        assign ld_en[i] = ld_valid && (int'(ld_slot) == i);

        srcc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok_link[i]),
            .ld_en   (ld_en[i]),
            .ld      (ld),
            .tok_out (tok_link[i+1])
        );
    end

    assign tok_out = tok_link[MAX_OBSTACLES];

endmodule

/* sv/segment_rect_collision_check_core.sv */
`timescale 1ns / 1ps

// Segment versus rectangle collision checker. Load beats (cmd 0) write one
// obstacle into a row of 16 cells, back to back while no check is busy. A
// check beat (cmd 1) enters a head register that tests the map bounds, then
// walks the cell row one cell per cycle; each cell tests both endpoints
// against its rectangle and the segment against its four sides. The result
// passes the head register, a register in each cell and the output register.
// No beat is taken while a check is in the row or its result is pending. A
// finished result waits in the output register (with one spare slot) while
// new beats are accepted. Configuration is written through cfg_wr_en.

`include "segment_rect_collision_check_core_defines.svh"

module segment_rect_collision_check_core import srcc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_cmd,
    input  logic [SLOT_BITS-1:0]    s_slot,
    input  logic [IN_BITS-1:0]      s_ax,
    input  logic [IN_BITS-1:0]      s_ay,
    input  logic [IN_BITS-1:0]      s_bx,
    input  logic [IN_BITS-1:0]      s_by_coord,
    input  logic [IN_BITS-1:0]      s_rect_left,
    input  logic [IN_BITS-1:0]      s_rect_bottom,
    input  logic [IN_BITS-1:0]      s_rect_width,
    input  logic [IN_BITS-1:0]      s_rect_height,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_path_free,
    output logic                    m_out_of_map,
    output logic                    m_endpoint_blocked,
    output logic                    m_edge_crossed,

    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [IN_BITS-1:0]      cfg_wdata
);

    logic [IN_BITS-1:0]    map_width_reg, map_height_reg;
    logic [COUNT_BITS-1:0] obst_count_reg;

    logic   in_accept, q_accept, ld_valid, out_free;
    logic   inflight_reg, pend_reg, m_valid_reg;
    res_t   out_res_reg, pend_res_reg, tail_res;
    token_t head_reg, head_next, tail_tok;
    load_t  ld;

    coord_t ax_c, ay_c, bx_c, by_c, mw_c, mh_c;
    cnt_t   rem_c;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= IN_BITS'(3200);
            map_height_reg <= IN_BITS'(3200);
            obst_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg  <= cfg_wdata;
                REG_MAP_HEIGHT: map_height_reg <= cfg_wdata;
                REG_OBST_COUNT: obst_count_reg <= cfg_wdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input handshake, one check in the row at a time
    assign s_ready   = !inflight_reg && !pend_reg;
    assign in_accept = s_valid && s_ready;
    assign q_accept  = in_accept && (s_cmd == CMD_CHECK);
    assign ld_valid  = in_accept && (s_cmd == CMD_LOAD);

    assign ld.left   = coord_of(s_rect_left);
    assign ld.bottom = coord_of(s_rect_bottom);
    assign ld.width  = coord_of(s_rect_width);
    assign ld.height = coord_of(s_rect_height);

    // head stage: bounds test, direction and active entry count
    always_comb begin
        ax_c = coord_of(s_ax);
        ay_c = coord_of(s_ay);
        bx_c = coord_of(s_bx);
        by_c = coord_of(s_by_coord);
        mw_c = coord_of(map_width_reg);
        mh_c = coord_of(map_height_reg);
        if (32'(obst_count_reg) > MAX_OBSTACLES) begin
            rem_c = cnt_t'(MAX_OBSTACLES);
        end else begin
            rem_c = cnt_t'(obst_count_reg);
        end

        head_next.valid   = q_accept;
        head_next.ax      = ax_c;
        head_next.ay      = ay_c;
        head_next.bx      = bx_c;
        head_next.by      = by_c;
        head_next.dpx     = diff_of_coord(bx_c) - diff_of_coord(ax_c);
        head_next.dpy     = diff_of_coord(by_c) - diff_of_coord(ay_c);
        head_next.rem     = rem_c;
        head_next.oom     = !((ax_c != '0) && (ay_c != '0) && (ax_c < mw_c) && (ay_c < mh_c))
                         || !((bx_c != '0) && (by_c != '0) && (bx_c < mw_c) && (by_c < mh_c));
        head_next.blocked = 1'b0;
        head_next.crossed = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg.valid <= 1'b0;
        end else begin
            head_reg <= head_next;
        end
    end

    srcc_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tok_in   (head_reg),
        .ld_valid (ld_valid),
        .ld_slot  (s_slot),
        .ld       (ld),
        .tok_out  (tail_tok)
    );

    assign tail_res.oom     = tail_tok.oom;
    assign tail_res.blocked = tail_tok.blocked;
    assign tail_res.crossed = tail_tok.crossed;
    assign out_free         = !m_valid_reg || m_ready;

    // busy tracking and output beat control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (q_accept) begin
                inflight_reg <= 1'b1;
            end else if (tail_tok.valid) begin
                inflight_reg <= 1'b0;
            end
            if (tail_tok.valid && !out_free) begin
                pend_reg <= 1'b1;
            end else if (pend_reg && out_free) begin
                pend_reg <= 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= tail_tok.valid || pend_reg;
            end
        end
    end

    // result payload, spare slot when the output is still held
    always_ff @(posedge aclk) begin
        if (tail_tok.valid && !out_free) begin
            pend_res_reg <= tail_res;
        end
        if (out_free) begin
            if (pend_reg) begin
                out_res_reg <= pend_res_reg;
            end else if (tail_tok.valid) begin
                out_res_reg <= tail_res;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_of_map       = out_res_reg.oom;
    assign m_endpoint_blocked = out_res_reg.blocked;
    assign m_edge_crossed     = out_res_reg.crossed;
    assign m_path_free        = !(out_res_reg.oom | out_res_reg.blocked | out_res_reg.crossed);

    // checks on the control flow
    `SRCC_ASSERT(a_busy_excl, !(inflight_reg && pend_reg), "check in flight with result pending")
    `SRCC_ASSERT(a_tail_owned, !tail_tok.valid || inflight_reg, "result left row with no check")
    `SRCC_ASSERT(a_pend_out, !pend_reg || m_valid_reg, "pending result with empty output")
    `SRCC_ASSERT_NEXT(a_check_busy, q_accept, !s_ready, "ready stayed high after check")

endmodule
